// ===== sv/pdv_pkg.sv =====
// Package with the shared types and constants of the position delta varint codec.
package pdv_pkg;

  localparam int unsigned PosW   = 14;
  localparam int unsigned DeltaW = 16;
  localparam int unsigned ShiftW = 5;

  localparam logic KindEncode = 1'b0;
  localparam logic KindDecode = 1'b1;

  localparam logic [DeltaW-1:0] FinalLimit = 16'h0020;
  localparam logic [ShiftW-1:0] GroupBits  = 5'd7;
  localparam logic [ShiftW-1:0] ShiftSat   = 5'd21;

  typedef struct packed {
    logic [1:0]       cnt;
    logic             is_pos;
    logic [2:0][7:0]  bytes;
    logic [PosW-1:0]  pos;
    logic [1:0]       wt;
  } res_t;

endpackage

// ===== sv/position_delta_varint_codec_unit.sv =====
// Top level of the position delta varint codec with its input register.
//
// The input channel takes one item per cycle while in_stall_o is low: an encode
// item (kind 0) carries a position and weight, a decode item (kind 1) carries one
// code byte. list_start clears the previous position of the matching direction
// before the item is used. An accepted item sits in an input register, then the
// encoder or decoder logic writes its results into a three-entry result buffer
// that feeds the output. An encode item gives one to three byte results, shown
// on consecutive cycles unless the receiver stalls; a decode item gives a
// position result on its final byte and none on a continuation byte. Decode items
// and one-byte encodes run at one item per cycle when the receiver does not stall;
// an encode item that yields several bytes holds the output until its last byte is
// taken, which sets the rate for long deltas. When the receiver stalls, the
// current result holds, the buffer stops draining, and in_stall_o rises once the
// input register cannot move on. Reset clears both previous positions, the decode
// accumulator and shift, and empties the input register and the buffer.
module position_delta_varint_codec_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic                     list_start_i,
  input  logic [pdv_pkg::PosW-1:0] position_i,
  input  logic [1:0]               weight_i,
  input  logic [7:0]               code_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     is_position_o,
  output logic [7:0]               out_byte_o,
  output logic [pdv_pkg::PosW-1:0] out_position_o,
  output logic [1:0]               out_weight_o,
  output logic                     last_o
);
  import pdv_pkg::*;

  logic            valid_q, valid_d;
  logic            kind_q, start_q;
  logic [PosW-1:0] position_q;
  logic [1:0]      weight_q;
  logic [7:0]      code_byte_q;
  logic            buf_free, adv, load_in;
  res_t            enc_res, dec_res, sel_res;

  always_comb begin
    adv        = valid_q && buf_free;
    in_stall_o = valid_q && !buf_free;
    load_in    = in_valid_i && !in_stall_o;
    valid_d    = load_in ? 1'b1 : (adv ? 1'b0 : valid_q);
    sel_res    = (kind_q == KindDecode) ? dec_res : enc_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      kind_q      <= kind_i;
      start_q     <= list_start_i;
      position_q  <= position_i;
      weight_q    <= weight_i;
      code_byte_q <= code_byte_i;
    end
  end

  pdv_enc u_enc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv && (kind_q == KindEncode)),
    .start_i    (start_q),
    .position_i (position_q),
    .weight_i   (weight_q),
    .res_o      (enc_res)
  );

  pdv_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (adv && (kind_q == KindDecode)),
    .start_i     (start_q),
    .code_byte_i (code_byte_q),
    .res_o       (dec_res)
  );

  pdv_obuf u_obuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (adv),
    .res_i          (sel_res),
    .free_o         (buf_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_position_o  (is_position_o),
    .out_byte_o     (out_byte_o),
    .out_position_o (out_position_o),
    .out_weight_o   (out_weight_o),
    .last_o         (last_o)
  );

endmodule

// ===== sv/pdv_enc.sv =====
// Encoder: previous-position register and the delta to varint byte split.
module pdv_enc (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic                    start_i,
  input  logic [pdv_pkg::PosW-1:0] position_i,
  input  logic [1:0]              weight_i,
  output pdv_pkg::res_t           res_o
);
  import pdv_pkg::*;

  logic [PosW-1:0]   prev_q;
  logic [PosW-1:0]   prev_d;
  logic [PosW-1:0]   prev_eff;
  logic [DeltaW-1:0] delta;
  logic [DeltaW-1:0] delta1;
  logic [DeltaW-1:0] delta2;

  always_comb begin
    prev_eff = start_i ? '0 : prev_q;
    delta    = {2'b00, position_i} - {2'b00, prev_eff};
    delta1   = delta >> 7;
    delta2   = delta1 >> 7;
    res_o        = '0;
    res_o.is_pos = 1'b0;
    if (delta >= FinalLimit) begin
      res_o.bytes[0] = {1'b1, delta[6:0]};
      if (delta1 >= FinalLimit) begin
        res_o.bytes[1] = {1'b1, delta1[6:0]};
        res_o.bytes[2] = {1'b0, weight_i, delta2[4:0]};
        res_o.cnt      = 2'd3;
      end else begin
        res_o.bytes[1] = {1'b0, weight_i, delta1[4:0]};
        res_o.cnt      = 2'd2;
      end
    end else begin
      res_o.bytes[0] = {1'b0, weight_i, delta[4:0]};
      res_o.cnt      = 2'd1;
    end
    prev_d = fire_i ? position_i : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// ===== sv/pdv_dec.sv =====
// Decoder: accumulator, shift and previous-position registers with the byte merge logic.
module pdv_dec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic          start_i,
  input  logic [7:0]    code_byte_i,
  output pdv_pkg::res_t res_o
);
  import pdv_pkg::*;

  logic [PosW-1:0]   prev_q, prev_d, prev_eff;
  logic [DeltaW-1:0] acc_q, acc_d, acc_eff, merged;
  logic [ShiftW-1:0] shift_q, shift_d, shift_eff, shift_inc;
  logic [PosW-1:0]   new_pos;
  logic              cont;

  always_comb begin
    prev_eff  = start_i ? '0 : prev_q;
    acc_eff   = start_i ? '0 : acc_q;
    shift_eff = start_i ? '0 : shift_q;
    cont      = code_byte_i[7];
    if (cont) begin
      merged = acc_eff | ({9'd0, code_byte_i[6:0]} << shift_eff);
    end else begin
      merged = acc_eff | ({11'd0, code_byte_i[4:0]} << shift_eff);
    end
    shift_inc = shift_eff + GroupBits;
    new_pos   = prev_eff + merged[PosW-1:0];

    res_o        = '0;
    res_o.is_pos = 1'b1;
    res_o.pos    = new_pos;
    res_o.wt     = code_byte_i[6:5];
    res_o.cnt    = cont ? 2'd0 : 2'd1;

    prev_d  = prev_q;
    acc_d   = acc_q;
    shift_d = shift_q;
    if (fire_i) begin
      if (cont) begin
        prev_d  = prev_eff;
        acc_d   = merged;
        shift_d = (shift_inc > ShiftSat) ? ShiftSat : shift_inc;
      end else begin
        prev_d  = new_pos;
        acc_d   = '0;
        shift_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      acc_q   <= '0;
      shift_q <= '0;
    end else begin
      prev_q  <= prev_d;
      acc_q   <= acc_d;
      shift_q <= shift_d;
    end
  end

endmodule

// ===== sv/pdv_obuf.sv =====
// Buffer of up to three results, handed out one per cycle unless stalled.
module pdv_obuf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  pdv_pkg::res_t            res_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     is_position_o,
  output logic [7:0]               out_byte_o,
  output logic [pdv_pkg::PosW-1:0] out_position_o,
  output logic [1:0]               out_weight_o,
  output logic                     last_o
);
  import pdv_pkg::*;

  logic [1:0]      cnt_q, cnt_d;
  logic [2:0][7:0] bytes_q, bytes_d;
  logic            is_pos_q, is_pos_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      wt_q, wt_d;
  logic            pop;

  always_comb begin
    pop      = (cnt_q != 2'd0) && !out_stall_i;
    free_o   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
    cnt_d    = cnt_q;
    bytes_d  = bytes_q;
    is_pos_d = is_pos_q;
    pos_d    = pos_q;
    wt_d     = wt_q;
    if (load_i) begin
      cnt_d    = res_i.cnt;
      bytes_d  = res_i.bytes;
      is_pos_d = res_i.is_pos;
      pos_d    = res_i.pos;
      wt_d     = res_i.wt;
    end else if (pop) begin
      cnt_d      = cnt_q - 2'd1;
      bytes_d[0] = bytes_q[1];
      bytes_d[1] = bytes_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    is_pos_q <= is_pos_d;
    pos_q    <= pos_d;
    wt_q     <= wt_d;
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign is_position_o  = is_pos_q;
  assign out_byte_o     = bytes_q[0];
  assign out_position_o = pos_q;
  assign out_weight_o   = wt_q;
  assign last_o         = (cnt_q == 2'd1);

endmodule

// ===== sv/pdv_checker.sv =====
// Port-level checker for the position delta varint codec and its bind statement.
module pdv_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     is_position_o,
  input logic [7:0]               out_byte_o,
  input logic [pdv_pkg::PosW-1:0] out_position_o,
  input logic [1:0]               out_weight_o,
  input logic                     last_o
);
  import pdv_pkg::*;

  a_pos_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_position_o) |-> last_o)
    else $error("Decoded position item is not marked last.");

  a_cont_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_position_o) |-> (out_byte_o[7] == !last_o))
    else $error("Encoded byte continuation bit disagrees with last.");

  a_enc_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_position_o) |-> (out_position_o == '0 && out_weight_o == 2'd0))
    else $error("Encoded byte item carries position fields.");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> (out_valid_o && !is_position_o))
    else $error("Encoded byte sequence broken before its last byte.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_byte_o) && $stable(last_o)))
    else $error("Stalled output item changed.");

endmodule

bind position_delta_varint_codec_unit pdv_checker u_pdv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .is_position_o  (is_position_o),
  .out_byte_o     (out_byte_o),
  .out_position_o (out_position_o),
  .out_weight_o   (out_weight_o),
  .last_o         (last_o)
);

// ===== tb/position_delta_varint_codec_checker.sv =====
// Checker that predicts and compares the results of the position delta varint codec.
`timescale 1ns / 100ps

module position_delta_varint_codec_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     kind_i,
  input  logic                     list_start_i,
  input  logic [pdv_pkg::PosW-1:0] position_i,
  input  logic [1:0]               weight_i,
  input  logic [7:0]               code_byte_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic                     is_position_i,
  input  logic [7:0]               out_byte_i,
  input  logic [pdv_pkg::PosW-1:0] out_position_i,
  input  logic [1:0]               out_weight_i,
  input  logic                     last_i,
  output int                       errors_o,
  output int                       pending_o
);

  import pdv_pkg::*;

  localparam logic [7:0] ContBit     = 8'h80;
  localparam logic [4:0] Low5Mask    = 5'h1F;
  localparam int unsigned WeightShift = 5;

  typedef struct packed {
    logic            is_position;
    logic [7:0]      out_byte;
    logic [PosW-1:0] out_position;
    logic [1:0]      out_weight;
    logic            last;
  } codec_result_t;

  codec_result_t      expected_results[$];
  logic [PosW-1:0]    enc_last_pos;
  logic [PosW-1:0]    dec_last_pos;
  logic [DeltaW-1:0]  dec_gathered;
  logic [ShiftW-1:0]  dec_offset;
  int                 mismatch_count;

  task automatic push_byte(input logic [7:0] value, input logic is_last);
    codec_result_t res;
    res = '0;
    res.out_byte = value;
    res.last = is_last;
    expected_results.push_back(res);
  endtask

  task automatic predict_item(input logic kind, input logic start,
                              input logic [PosW-1:0] pos, input logic [1:0] wt,
                              input logic [7:0] cbyte);
    logic [DeltaW-1:0] diff;
    logic [31:0]       group;
    logic [5:0]        next_offset;
    logic [PosW-1:0]   new_pos;
    codec_result_t     res;
    int                n;
    if (kind == KindEncode) begin
      if (start) enc_last_pos = '0;
      diff = {2'b00, pos} - {2'b00, enc_last_pos};
      n = 0;
      while (diff >= FinalLimit && n < 2) begin
        push_byte(ContBit | {1'b0, diff[6:0]}, 1'b0);
        diff = diff >> GroupBits;
        n++;
      end
      push_byte({1'b0, wt, diff[4:0] & Low5Mask}, 1'b1);
      enc_last_pos = pos;
    end else begin
      if (start) begin
        dec_last_pos = '0;
        dec_gathered = '0;
        dec_offset   = '0;
      end
      if (cbyte[7]) begin
        group = {25'd0, cbyte[6:0]} << dec_offset;
        dec_gathered = dec_gathered | group[DeltaW-1:0];
        next_offset = {1'b0, dec_offset} + {1'b0, GroupBits};
        if (next_offset > {1'b0, ShiftSat}) next_offset = {1'b0, ShiftSat};
        dec_offset = next_offset[ShiftW-1:0];
      end else begin
        group = {27'd0, cbyte[4:0] & Low5Mask} << dec_offset;
        diff = dec_gathered | group[DeltaW-1:0];
        new_pos = dec_last_pos + diff[PosW-1:0];
        res = '0;
        res.is_position  = 1'b1;
        res.out_position = new_pos;
        res.out_weight   = cbyte[WeightShift +: 2];
        res.last         = 1'b1;
        expected_results.push_back(res);
        dec_last_pos = new_pos;
        dec_gathered = '0;
        dec_offset   = '0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic compare_result();
    codec_result_t exp_r;
    if (expected_results.size() == 0) begin
      $error("result item arrived with nothing expected");
      mismatch_count++;
    end else begin
      exp_r = expected_results.pop_front();
      check_field("is_position", 16'(exp_r.is_position), 16'(is_position_i));
      check_field("out_byte", 16'(exp_r.out_byte), 16'(out_byte_i));
      check_field("out_position", 16'(exp_r.out_position), 16'(out_position_i));
      check_field("out_weight", 16'(exp_r.out_weight), 16'(out_weight_i));
      check_field("last", 16'(exp_r.last), 16'(last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_last_pos   = '0;
      dec_last_pos   = '0;
      dec_gathered   = '0;
      dec_offset     = '0;
      mismatch_count = 0;
      expected_results.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) begin
        predict_item(kind_i, list_start_i, position_i, weight_i, code_byte_i);
      end
      errors_o  <= mismatch_count;
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== tb/tb_position_delta_varint_codec_unit.sv =====
// Testbench top that drives the position delta varint codec and reports the verdict.
`timescale 1ns / 100ps

module tb_position_delta_varint_codec_unit;

  import pdv_pkg::*;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                kind         = KindEncode;
  logic                list_start   = 1'b0;
  logic [PosW-1:0]     position     = '0;
  logic [1:0]          weight       = '0;
  logic [7:0]          code_byte    = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                is_position;
  logic [7:0]          out_byte;
  logic [PosW-1:0]     out_position;
  logic [1:0]          out_weight;
  logic                res_last;
  int                  mismatches;
  int                  outstanding;
  int                  item_count   = 0;
  logic                quiet        = 1'b0;
  logic [PosW-1:0]     last_enc_pos = '0;

  position_delta_varint_codec_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .list_start_i   (list_start),
    .position_i     (position),
    .weight_i       (weight),
    .code_byte_i    (code_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .is_position_o  (is_position),
    .out_byte_o     (out_byte),
    .out_position_o (out_position),
    .out_weight_o   (out_weight),
    .last_o         (res_last)
  );

  position_delta_varint_codec_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (kind),
    .list_start_i   (list_start),
    .position_i     (position),
    .weight_i       (weight),
    .code_byte_i    (code_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .is_position_i  (is_position),
    .out_byte_i     (out_byte),
    .out_position_i (out_position),
    .out_weight_i   (out_weight),
    .last_i         (res_last),
    .errors_o       (mismatches),
    .pending_o      (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 20);
    end
  end

  task automatic send_item(input logic kind_v, input logic start_v,
                           input logic [PosW-1:0] pos_v, input logic [1:0] wt_v,
                           input logic [7:0] byte_v);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    kind       <= kind_v;
    list_start <= start_v;
    position   <= pos_v;
    weight     <= wt_v;
    code_byte  <= byte_v;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    item_count++;
  endtask

  task automatic send_encode(input logic start_v, input logic [PosW-1:0] pos_v,
                             input logic [1:0] wt_v);
    send_item(KindEncode, start_v, pos_v, wt_v, 8'($urandom));
    last_enc_pos = pos_v;
  endtask

  task automatic send_decode(input logic start_v, input logic [7:0] byte_v);
    send_item(KindDecode, start_v, PosW'($urandom), 2'($urandom), byte_v);
  endtask

  task automatic send_random_code(input logic start_v, input int n_cont);
    for (int i = 0; i < n_cont; i++) begin
      send_decode(start_v && (i == 0), 8'h80 | 8'($urandom_range(0, 127)));
    end
    send_decode(start_v && (n_cont == 0), 8'($urandom_range(0, 127)));
  endtask

  initial begin
    logic [PosW-1:0] base;
    logic [PosW-1:0] pos_v;
    logic            start_v;
    int              pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_encode(1'b1, 14'd0, 2'd0);
    send_encode(1'b0, 14'd31, 2'd3);
    send_encode(1'b0, 14'd63, 2'd1);
    send_encode(1'b0, 14'd16383, 2'd2);
    send_encode(1'b0, 14'd0, 2'd3);
    send_encode(1'b1, 14'd16383, 2'd1);
    send_decode(1'b1, 8'h00);
    send_decode(1'b0, 8'h7F);
    send_decode(1'b0, 8'hFF);
    send_decode(1'b0, 8'hFF);
    send_decode(1'b0, 8'h7F);
    for (int i = 0; i < 5; i++) send_decode(1'b0, 8'h81);
    send_decode(1'b0, 8'h1F);
    // A list start in the middle of a code drops the half-built difference.
    send_decode(1'b0, 8'h85);
    send_decode(1'b1, 8'h42);
    // Encode items between the bytes of one code leave the decode state alone.
    send_decode(1'b0, 8'h83);
    send_encode(1'b0, 14'd100, 2'd2);
    send_decode(1'b0, 8'h01);

    while (item_count < 220) begin
      quiet = (item_count >= 110) && (item_count < 160);
      pick = $urandom_range(0, 99);
      start_v = ($urandom_range(0, 9) == 0);
      if (pick < 45) begin
        base = start_v ? '0 : last_enc_pos;
        case ($urandom_range(0, 3))
          0: pos_v = base + PosW'($urandom_range(0, 31));
          1: pos_v = base + PosW'($urandom_range(32, 4095));
          default: pos_v = PosW'($urandom);
        endcase
        send_encode(start_v, pos_v, 2'($urandom));
      end else if (pick < 85) begin
        send_random_code(start_v, ($urandom_range(0, 9) == 0) ?
                         $urandom_range(3, 5) : $urandom_range(0, 2));
      end else begin
        send_decode(start_v, 8'($urandom));
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk_i);

    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pdv_pkg.sv
sv/pdv_enc.sv
sv/pdv_dec.sv
sv/pdv_obuf.sv
sv/position_delta_varint_codec_unit.sv
sv/pdv_checker.sv
tb/position_delta_varint_codec_checker.sv
tb/tb_position_delta_varint_codec_unit.sv
